FILE: hw/rtl/rdt_pkg.sv
package rdt_pkg;

    localparam int COUNT_BITS    = 12;
    localparam int DATA_BITS     = 16;
    localparam int OP_BITS       = 3;
    localparam int PERIOD_BITS   = 2;
    localparam int PRESCALE_BITS = 4;

    localparam int CTRL_ENABLE_BIT  = 0;
    localparam int CTRL_PERIOD_LSB  = 1;
    localparam int CTRL_IRQ_EN_BIT  = 6;

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK      = 3'd0,
        OP_WR_CTRL   = 3'd1,
        OP_WR_RELOAD = 3'd2,
        OP_RD_STATUS = 3'd3,
        OP_RD_COUNT  = 3'd4,
        OP_IRQ_ACK   = 3'd5
    } t_opcode;

    typedef struct packed {
        logic [OP_BITS-1:0]   opcode;
        logic [DATA_BITS-1:0] write_data;
    } t_item;

    typedef struct packed {
        logic [COUNT_BITS-1:0]  count_value;
        logic                   done_flag;
        logic                   overflow_flag;
        logic                   irq_enabled;
        logic                   running;
        logic [PERIOD_BITS-1:0] period_select;
        logic                   irq_request;
        logic                   ack_granted;
    } t_result;

endpackage

FILE: hw/rtl/rdt_in_if.sv
interface rdt_in_if import rdt_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [OP_BITS-1:0]   opcode;
    logic [DATA_BITS-1:0] write_data;

    modport source (output valid, output opcode, output write_data, input ready);
    modport sink   (input valid, input opcode, input write_data, output ready);
endinterface

FILE: hw/rtl/rdt_out_if.sv
interface rdt_out_if import rdt_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [COUNT_BITS-1:0]  count_value;
    logic                   done_flag;
    logic                   overflow_flag;
    logic                   irq_enabled;
    logic                   running;
    logic [PERIOD_BITS-1:0] period_select;
    logic                   irq_request;
    logic                   ack_granted;

    modport source (
        output valid, output count_value, output done_flag, output overflow_flag,
        output irq_enabled, output running, output period_select, output irq_request,
        output ack_granted, input ready
    );
    modport sink (
        input valid, input count_value, input done_flag, input overflow_flag,
        input irq_enabled, input running, input period_select, input irq_request,
        input ack_granted, output ready
    );
endinterface

FILE: hw/rtl/rdt_in_reg.sv
module rdt_in_reg import rdt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rdt_in_if.sink i_in,
    input  logic   i_go,
    output logic   o_valid,
    output t_item  o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  load;

    assign i_in.ready = !r_valid || i_go;
    assign load       = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_go) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.opcode     <= i_in.opcode;
            r_item.write_data <= i_in.write_data;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: hw/rtl/rdt_core.sv
module rdt_core import rdt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_go,
    input  t_item   i_item,
    output t_result o_result
);

    logic                     r_enable,       n_enable;
    logic [PERIOD_BITS-1:0]   r_period,       n_period;
    logic                     r_irq_enable,   n_irq_enable;
    logic                     r_done,         n_done;
    logic                     r_overflow,     n_overflow;
    logic [COUNT_BITS-1:0]    r_reload,       n_reload;
    logic [COUNT_BITS-1:0]    r_down,         n_down;
    logic [COUNT_BITS-1:0]    r_shown,        n_shown;
    logic [PRESCALE_BITS-1:0] r_prescale,     n_prescale;
    logic                     r_irq_pending,  n_irq_pending;

    logic [PRESCALE_BITS-1:0] last;
    logic [COUNT_BITS-1:0]    dec;
    logic                     fire;
    logic                     ack;
    logic                     new_ie;
    t_opcode                  op;

    assign op     = t_opcode'(i_item.opcode);
    assign new_ie = i_item.write_data[CTRL_IRQ_EN_BIT];
    assign last   = PRESCALE_BITS'((5'd2 << r_period) - 5'd1);
    assign dec    = r_down - 1'b1;

    always_comb begin
        n_enable      = r_enable;
        n_period      = r_period;
        n_irq_enable  = r_irq_enable;
        n_done        = r_done;
        n_overflow    = r_overflow;
        n_reload      = r_reload;
        n_down        = r_down;
        n_shown       = r_shown;
        n_prescale    = r_prescale;
        n_irq_pending = r_irq_pending;
        fire          = 1'b0;
        ack           = 1'b0;

        case (op)
            OP_TICK: begin
                if (r_enable) begin
                    if (r_prescale >= last) begin
                        n_prescale = '0;
                        fire       = 1'b1;
                    end else begin
                        n_prescale = r_prescale + 1'b1;
                    end
                end
            end
            OP_WR_CTRL: begin
                if (!new_ie) begin
                    n_irq_pending = 1'b0;
                end else if (r_done && !r_irq_enable) begin
                    n_irq_pending = 1'b1;
                end
                n_enable     = i_item.write_data[CTRL_ENABLE_BIT];
                n_period     = i_item.write_data[CTRL_PERIOD_LSB +: PERIOD_BITS];
                n_irq_enable = new_ie;
                n_prescale   = '0;
            end
            OP_WR_RELOAD: begin
                n_reload = i_item.write_data[COUNT_BITS-1:0];
                if (!r_enable) begin
                    n_down  = i_item.write_data[COUNT_BITS-1:0];
                    n_shown = i_item.write_data[COUNT_BITS-1:0];
                end
            end
            OP_RD_STATUS: begin
                n_overflow = 1'b0;
            end
            OP_RD_COUNT: begin
                n_done        = 1'b0;
                n_irq_pending = 1'b0;
            end
            OP_IRQ_ACK: begin
                if (r_irq_pending) begin
                    n_irq_pending = 1'b0;
                    ack           = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // decrement on fire; reload and flag on reaching zero
        if (fire && (r_down != '0)) begin
            if (dec == '0) begin
                n_overflow = r_overflow | r_done;
                n_done     = 1'b1;
                if (r_irq_enable) begin
                    n_irq_pending = 1'b1;
                end
                n_down  = r_reload;
                n_shown = r_reload;
            end else begin
                n_down  = dec;
                n_shown = dec;
            end
        end
    end

    always_comb begin
        o_result.count_value   = n_shown;
        o_result.done_flag     = (op == OP_RD_COUNT)  ? r_done     : n_done;
        o_result.overflow_flag = (op == OP_RD_STATUS) ? r_overflow : n_overflow;
        o_result.irq_enabled   = n_irq_enable;
        o_result.running       = n_enable;
        o_result.period_select = n_period;
        o_result.irq_request   = n_irq_pending;
        o_result.ack_granted   = ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_period      <= '0;
            r_irq_enable  <= 1'b0;
            r_done        <= 1'b0;
            r_overflow    <= 1'b0;
            r_reload      <= '0;
            r_down        <= '0;
            r_shown       <= '0;
            r_prescale    <= '0;
            r_irq_pending <= 1'b0;
        end else if (i_go) begin
            r_enable      <= n_enable;
            r_period      <= n_period;
            r_irq_enable  <= n_irq_enable;
            r_done        <= n_done;
            r_overflow    <= n_overflow;
            r_reload      <= n_reload;
            r_down        <= n_down;
            r_shown       <= n_shown;
            r_prescale    <= n_prescale;
            r_irq_pending <= n_irq_pending;
        end
    end

    a_ovf_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_overflow) |-> $past(r_done))
        else $error("overflow set without done");

    a_irq_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_irq_pending) |-> r_irq_enable)
        else $error("request raised with interrupts disabled");

    a_count_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && op == OP_RD_COUNT) |=> (!r_done && !r_irq_pending))
        else $error("count read left done or request set");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_go |=> ($stable(r_down) && $stable(r_prescale) && $stable(r_done)))
        else $error("timer state moved without an item");

endmodule

FILE: hw/rtl/rdt_out_reg.sv
module rdt_out_reg import rdt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_result    i_result,
    rdt_out_if.source  o_out,
    output logic       o_go
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_go = i_valid && (!r_valid || o_out.ready);

    always_comb begin
        n_valid = r_valid;
        if (o_go) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_go) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.count_value   = r_result.count_value;
    assign o_out.done_flag     = r_result.done_flag;
    assign o_out.overflow_flag = r_result.overflow_flag;
    assign o_out.irq_enabled   = r_result.irq_enabled;
    assign o_out.running       = r_result.running;
    assign o_out.period_select = r_result.period_select;
    assign o_out.irq_request   = r_result.irq_request;
    assign o_out.ack_granted   = r_result.ack_granted;

endmodule

FILE: hw/rtl/reload_down_timer_regs.sv
// Reload down-timer behind bus registers.
// i_in carries one item per access: opcode (base tick, control write, reload
// write, status read, count read, interrupt acknowledge) and write_data.
// o_out returns exactly one result item per accepted item: shown count, done,
// overflow, interrupt enable, run bit, period select, request level and ack.
// Each item waits in the input register until go; then the timer registers update
// and its result is loaded into the result register. A stall on o_out holds go low.
// Throughput: one item per cycle unless o_out stalls, set by the single
// update of the timer registers between the input and result registers.
// The input side keeps accepting while a finished result waits, as long as
// the input register can move on; when the receiver stalls, one result and one
// item are held and i_in.ready drops until o_out.ready returns.
// Reset (i_rst_n low, synchronous) clears all timer state and both registers'
// valid bits; the block accepts items in the first cycle after reset.
module reload_down_timer_regs import rdt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rdt_in_if.sink    i_in,
    rdt_out_if.source o_out
);

    logic    go;
    logic    item_valid;
    t_item   item;
    t_result result;

    rdt_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_go    (go),
        .o_valid (item_valid),
        .o_item  (item)
    );

    rdt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (item),
        .o_result (result)
    );

    rdt_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (item_valid),
        .i_result (result),
        .o_out    (o_out),
        .o_go     (go)
    );

endmodule

FILE: tb/rdt_result_checker.sv
`timescale 1ns / 100ps

module rdt_result_checker import rdt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    rdt_in_if    i_items,
    rdt_out_if   i_results,
    output int   o_fail_count,
    output int   o_pending
);

    logic                     run_en;
    logic [PERIOD_BITS-1:0]   period_sel;
    logic                     irq_en;
    logic                     done_st;
    logic                     ovf_st;
    logic [COUNT_BITS-1:0]    reload_val;
    logic [COUNT_BITS-1:0]    down_cnt;
    logic [COUNT_BITS-1:0]    shown_cnt;
    logic [PRESCALE_BITS-1:0] prescale;
    logic                     irq_pend;
    t_result                  timer_views_due[$];

    function automatic t_result timer_apply(input t_opcode op, input logic [DATA_BITS-1:0] wd);
        t_result                  view;
        logic [PRESCALE_BITS-1:0] last;
        view = '0;
        case (op)
            OP_TICK: begin
                if (run_en) begin
                    last = PRESCALE_BITS'((32'd2 << period_sel) - 32'd1);
                    if (prescale >= last) begin
                        prescale = '0;
                        // fire: a zero counter holds
                        if (down_cnt != '0) begin
                            down_cnt = down_cnt - 1'b1;
                            if (down_cnt == '0) begin
                                if (done_st) begin
                                    ovf_st = 1'b1;
                                end
                                done_st = 1'b1;
                                if (irq_en) begin
                                    irq_pend = 1'b1;
                                end
                                down_cnt  = reload_val;
                                shown_cnt = reload_val;
                            end else begin
                                shown_cnt = down_cnt;
                            end
                        end
                    end else begin
                        prescale = prescale + 1'b1;
                    end
                end
            end
            OP_WR_CTRL: begin
                if (!wd[CTRL_IRQ_EN_BIT]) begin
                    irq_pend = 1'b0;
                end else if (done_st && !irq_en) begin
                    irq_pend = 1'b1;
                end
                run_en     = wd[CTRL_ENABLE_BIT];
                period_sel = wd[CTRL_PERIOD_LSB +: PERIOD_BITS];
                irq_en     = wd[CTRL_IRQ_EN_BIT];
                prescale   = '0;
            end
            OP_WR_RELOAD: begin
                reload_val = wd[COUNT_BITS-1:0];
                if (!run_en) begin
                    down_cnt  = reload_val;
                    shown_cnt = reload_val;
                end
            end
            default: ;
        endcase
        // reads report the flag as seen before their clear
        view.done_flag     = done_st;
        view.overflow_flag = ovf_st;
        case (op)
            OP_RD_STATUS: ovf_st = 1'b0;
            OP_RD_COUNT: begin
                done_st  = 1'b0;
                irq_pend = 1'b0;
            end
            OP_IRQ_ACK: begin
                view.ack_granted = irq_pend;
                irq_pend         = 1'b0;
            end
            default: ;
        endcase
        view.count_value   = shown_cnt;
        view.irq_enabled   = irq_en;
        view.running       = run_en;
        view.period_select = period_sel;
        view.irq_request   = irq_pend;
        return view;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            run_en     = 1'b0;
            period_sel = '0;
            irq_en     = 1'b0;
            done_st    = 1'b0;
            ovf_st     = 1'b0;
            reload_val = '0;
            down_cnt   = '0;
            shown_cnt  = '0;
            prescale   = '0;
            irq_pend   = 1'b0;
            timer_views_due.delete();
        end else begin
            if (i_results.valid && i_results.ready) begin
                got = {i_results.count_value, i_results.done_flag, i_results.overflow_flag,
                       i_results.irq_enabled, i_results.running, i_results.period_select,
                       i_results.irq_request, i_results.ack_granted};
                if (timer_views_due.size() == 0) begin
                    $display("%0t: result expected none got %p", $time, got);
                    o_fail_count++;
                end else begin
                    want = timer_views_due.pop_front();
                    check_field("count_value", 16'(want.count_value), 16'(got.count_value));
                    check_field("done_flag", 16'(want.done_flag), 16'(got.done_flag));
                    check_field("overflow_flag", 16'(want.overflow_flag),
                                16'(got.overflow_flag));
                    check_field("irq_enabled", 16'(want.irq_enabled), 16'(got.irq_enabled));
                    check_field("running", 16'(want.running), 16'(got.running));
                    check_field("period_select", 16'(want.period_select),
                                16'(got.period_select));
                    check_field("irq_request", 16'(want.irq_request), 16'(got.irq_request));
                    check_field("ack_granted", 16'(want.ack_granted), 16'(got.ack_granted));
                end
            end
            if (i_items.valid && i_items.ready) begin
                timer_views_due.push_back(timer_apply(t_opcode'(i_items.opcode),
                                                      i_items.write_data));
            end
        end
        o_pending <= timer_views_due.size();
    end

endmodule

FILE: tb/tb_reload_down_timer_regs.sv
`timescale 1ns / 100ps

module tb_reload_down_timer_regs;
    import rdt_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   views_pending;
    int   send_quiet;
    int   ready_quiet;

    rdt_in_if  in_ch ();
    rdt_out_if out_ch ();

    reload_down_timer_regs dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rdt_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_items      (in_ch),
        .i_results    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (views_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("[reload_down_timer_regs] ERROR");
        $finish;
    end

    // draw a random wait, with occasional stretches of none
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            quiet_left = $urandom_range(8, 40);
        end
        return $urandom_range(0, 6);
    endfunction

    task automatic send_item(input t_opcode op, input logic [DATA_BITS-1:0] wd);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.write_data <= wd;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        ready_quiet = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait(ready_quiet);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin
        int                   pick;
        logic [DATA_BITS-1:0] wd;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.opcode     <= OP_TICK;
        in_ch.write_data <= '0;
        send_quiet = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_RD_STATUS, 16'h0000);
        send_item(OP_RD_COUNT, 16'h0000);
        send_item(OP_IRQ_ACK, 16'h0000);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_WR_RELOAD, 16'hFFFF);
        send_item(OP_RD_COUNT, 16'hFFFF);
        send_item(OP_WR_RELOAD, 16'hF002);
        send_item(OP_WR_CTRL, 16'hFFC9);
        repeat (4) send_item(OP_TICK, 16'h0000);
        send_item(OP_WR_RELOAD, 16'h0001);
        repeat (4) send_item(OP_TICK, 16'h5A5A);
        send_item(OP_RD_STATUS, 16'h0000);
        send_item(OP_IRQ_ACK, 16'h0000);
        send_item(OP_IRQ_ACK, 16'h0000);
        send_item(OP_WR_CTRL, 16'h0001);
        send_item(OP_WR_CTRL, 16'h0047);
        send_item(OP_RD_COUNT, 16'h0000);
        send_item(OP_WR_CTRL, 16'h0000);
        send_item(OP_WR_RELOAD, 16'h0000);

        // mostly ticks on a running timer with short reloads, so zero is reached often
        for (int n = 0; n < 650; n++) begin
            pick = $urandom_range(0, 99);
            wd   = 16'($urandom);
            if (pick < 55) begin
                send_item(OP_TICK, wd);
            end else if (pick < 64) begin
                if ($urandom_range(0, 4) != 0) begin
                    wd[CTRL_ENABLE_BIT] = 1'b1;
                end
                if ($urandom_range(0, 1) != 0) begin
                    wd[CTRL_PERIOD_LSB +: PERIOD_BITS] = PERIOD_BITS'($urandom_range(0, 1));
                end
                send_item(OP_WR_CTRL, wd);
            end else if (pick < 71) begin
                if ($urandom_range(0, 5) != 0) begin
                    wd[COUNT_BITS-1:0] = COUNT_BITS'($urandom_range(0, 6));
                end
                send_item(OP_WR_RELOAD, wd);
            end else if (pick < 81) begin
                send_item(OP_RD_STATUS, wd);
            end else if (pick < 90) begin
                send_item(OP_RD_COUNT, wd);
            end else begin
                send_item(OP_IRQ_ACK, wd);
            end
        end

        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (views_pending != 0);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[reload_down_timer_regs] OK");
        end else begin
            $display("[reload_down_timer_regs] ERROR");
        end
        $finish;
    end

endmodule
